// File: hdl/sfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

  // frame layout and check values
  localparam logic [15:0] FrameHeader   = 16'h55AA;
  localparam logic [15:0] FrameLength   = 16'd23;
  localparam logic [7:0]  StatusCommand = 8'h02;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;

  localparam int PosWidth     = 5;
  localparam int OutDataWidth = 136;

  // byte positions inside the frame
  localparam logic [PosWidth-1:0] PosHeaderFirst  = 5'd0;
  localparam logic [PosWidth-1:0] PosHeaderLast   = 5'd1;
  localparam logic [PosWidth-1:0] PosLengthFirst  = 5'd2;
  localparam logic [PosWidth-1:0] PosLengthLast   = 5'd3;
  localparam logic [PosWidth-1:0] PosCommand      = 5'd4;
  localparam logic [PosWidth-1:0] PosLSpeedFirst  = 5'd5;
  localparam logic [PosWidth-1:0] PosLSpeedLast   = 5'd8;
  localparam logic [PosWidth-1:0] PosRSpeedFirst  = 5'd9;
  localparam logic [PosWidth-1:0] PosRSpeedLast   = 5'd12;
  localparam logic [PosWidth-1:0] PosLAngleFirst  = 5'd13;
  localparam logic [PosWidth-1:0] PosLAngleLast   = 5'd16;
  localparam logic [PosWidth-1:0] PosRAngleFirst  = 5'd17;
  localparam logic [PosWidth-1:0] PosRAngleLast   = 5'd20;
  localparam logic [PosWidth-1:0] PosCheckHigh    = 5'd21;
  localparam logic [PosWidth-1:0] PosCheckLow     = 5'd22;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_LENGTH = 3'd2,
    ST_BAD_CMD    = 3'd3,
    ST_BAD_CRC    = 3'd4
  } frame_status_t;

  // captured frame contents handed to the result stage
  typedef struct packed {
    logic [15:0] header;
    logic [15:0] length;
    logic [7:0]  command;
    logic [31:0] left_speed;
    logic [31:0] right_speed;
    logic [31:0] left_angle;
    logic [31:0] right_angle;
    logic [7:0]  check_high;
    logic [15:0] crc;
    logic        last_byte;
  } frame_fields_t;

  // crc-16/modbus update for one byte, reflected, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/status_frame_parser_crc16_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   ports                       contents
// in        in    in_tvalid/tready/tdata      one frame byte, data_byte [7:0]
// out       out   out_tvalid/tready/tdata     status and four values, one per frame
//
// one byte per cycle while in_tready is high; the crc update is combinational ahead of the crc
// register, and all field checks are combinational between the capture and output registers.
// a result appears in the cycle after the 23rd byte of a frame is taken.
// reset clears the byte position and the output valid, and sets the crc to its initial value.
// output stall only holds off the last byte of the next frame, others flow on.

module status_frame_parser_crc16_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // [7:0] data_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [2:0] frame_status, [34:3] left_speed, [66:35] right_speed,
  // [98:67] left_angle, [130:99] right_angle, [135:131] zero
  output logic [sfp_pkg::OutDataWidth-1:0]   out_tdata
);

  sfp_pkg::frame_fields_t fields;
  logic slot_free;
  logic byte_accept;

  assign in_tready   = !fields.last_byte || slot_free;
  assign byte_accept = in_tvalid && in_tready;

  sfp_capture u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .data_byte   (in_tdata),
    .fields      (fields)
  );

  sfp_result u_result (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .data_byte   (in_tdata),
    .fields      (fields),
    .slot_free   (slot_free),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

`default_nettype wire

// File: hdl/sfp_capture.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_capture (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  byte_accept,
  input  wire logic [7:0]            data_byte,
  output sfp_pkg::frame_fields_t     fields
);

  logic [sfp_pkg::PosWidth-1:0] pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] header_r, length_r;
  logic [7:0]  command_r, check_high_r;
  logic [31:0] lspeed_r, rspeed_r, langle_r, rangle_r;
  logic        last_byte;

  assign last_byte = (pos_r == sfp_pkg::PosCheckLow);

  // position counter and crc over bytes 2..20
  always_comb begin
    pos_nxt = last_byte ? '0 : pos_r + 1'b1;
    crc_nxt = crc_r;
    if (last_byte) begin
      crc_nxt = sfp_pkg::CrcInit;
    end else if (pos_r >= sfp_pkg::PosLengthFirst && pos_r <= sfp_pkg::PosRAngleLast) begin
      crc_nxt = sfp_pkg::crc16_byte(crc_r, data_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= sfp_pkg::CrcInit;
    end else if (byte_accept) begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  // field shift registers, msb first
  always_ff @(posedge clk) begin
    if (byte_accept) begin
      case (pos_r) inside
        [sfp_pkg::PosHeaderFirst:sfp_pkg::PosHeaderLast]:
          header_r <= {header_r[7:0], data_byte};
        [sfp_pkg::PosLengthFirst:sfp_pkg::PosLengthLast]:
          length_r <= {length_r[7:0], data_byte};
        sfp_pkg::PosCommand:
          command_r <= data_byte;
        [sfp_pkg::PosLSpeedFirst:sfp_pkg::PosLSpeedLast]:
          lspeed_r <= {lspeed_r[23:0], data_byte};
        [sfp_pkg::PosRSpeedFirst:sfp_pkg::PosRSpeedLast]:
          rspeed_r <= {rspeed_r[23:0], data_byte};
        [sfp_pkg::PosLAngleFirst:sfp_pkg::PosLAngleLast]:
          langle_r <= {langle_r[23:0], data_byte};
        [sfp_pkg::PosRAngleFirst:sfp_pkg::PosRAngleLast]:
          rangle_r <= {rangle_r[23:0], data_byte};
        sfp_pkg::PosCheckHigh:
          check_high_r <= data_byte;
        default: ;
      endcase
    end
  end

  assign fields.header      = header_r;
  assign fields.length      = length_r;
  assign fields.command     = command_r;
  assign fields.left_speed  = lspeed_r;
  assign fields.right_speed = rspeed_r;
  assign fields.left_angle  = langle_r;
  assign fields.right_angle = rangle_r;
  assign fields.check_high  = check_high_r;
  assign fields.crc         = crc_r;
  assign fields.last_byte   = last_byte;

endmodule

`default_nettype wire

// File: hdl/sfp_result.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_result (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                byte_accept,
  input  wire logic [7:0]                          data_byte,
  input  sfp_pkg::frame_fields_t                   fields,
  output logic                                     slot_free,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [sfp_pkg::OutDataWidth-1:0]         out_tdata
);

  sfp_pkg::frame_status_t status;
  logic [15:0] received;
  logic [127:0] values;
  logic valid_r, valid_nxt;
  logic [sfp_pkg::OutDataWidth-1:0] data_r;
  logic load;

  // checks in priority order
  assign received = {fields.check_high, data_byte};
  always_comb begin
    if (fields.header != sfp_pkg::FrameHeader)       status = sfp_pkg::ST_BAD_HEADER;
    else if (fields.length != sfp_pkg::FrameLength)  status = sfp_pkg::ST_BAD_LENGTH;
    else if (fields.command != sfp_pkg::StatusCommand) status = sfp_pkg::ST_BAD_CMD;
    else if (received != fields.crc)                 status = sfp_pkg::ST_BAD_CRC;
    else                                             status = sfp_pkg::ST_OK;
  end

  // values only pass on a good frame
  assign values = (status == sfp_pkg::ST_OK) ?
                  {fields.right_angle, fields.left_angle, fields.right_speed, fields.left_speed} :
                  '0;

  // output register
  assign slot_free = !valid_r || out_tready;
  assign load      = byte_accept && fields.last_byte;

  always_comb begin
    valid_nxt = valid_r;
    if (load)            valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= {5'b0, values, status};
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

`default_nettype wire
